@@ design/mpbm_pkg.sv @@
// shared types and constants of the multi-pattern byte matcher
`default_nettype none

package mpbm_pkg;

  // field widths fixed by the request and result formats
  localparam int SYM_W = 8;
  localparam int ID_W = 5;
  localparam int POS_W = 32;

  // default sizes handed to the top level
  localparam int MAX_NODES_DEF = 256;
  localparam int MAX_PATTERNS_DEF = 32;
  localparam int ALPHABET_DEF = 256;

  // most results one scan byte may give
  localparam int RESULT_CAP = 32;
  localparam int CNT_W = $clog2(RESULT_CAP + 1);

  // request operations
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_BUILD = 2'd2,
    OP_SCAN  = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_MATCH = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t              op;
    logic [SYM_W-1:0] symbol;
    logic             pattern_end;
    logic [ID_W-1:0]  pattern_id;
  } in_t;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] position;
    logic [ID_W-1:0]  match_id;
    logic             last;
  } out_t;

  // classified request between front and back
  typedef struct packed {
    op_t              op;
    logic [SYM_W-1:0] symbol;
    logic             sym_ok;
    logic             pattern_end;
    logic [ID_W-1:0]  pattern_id;
    logic             pid_ok;
  } cmd_t;

endpackage

`default_nettype wire

@@ design/mpbm_front.sv @@
// request intake and classification
`default_nettype none

module mpbm_front #(
  parameter int MAX_PATTERNS = mpbm_pkg::MAX_PATTERNS_DEF,
  parameter int ALPHABET = mpbm_pkg::ALPHABET_DEF
) (
  input  wire logic          cmd_valid,
  output logic               cmd_stall,
  input  wire mpbm_pkg::in_t cmd,
  input  wire logic          full,
  output logic               push,
  output mpbm_pkg::cmd_t     push_cmd
);

  localparam int SC_W = mpbm_pkg::SYM_W + 1;
  localparam int PC_W = mpbm_pkg::ID_W + 2;

  // take a request whenever the queue has room
  assign cmd_stall = full;
  assign push = cmd_valid && !full;

  // range checks on symbol and pattern number
  always_comb begin
    push_cmd.op = cmd.op;
    push_cmd.symbol = cmd.symbol;
    push_cmd.sym_ok = {1'b0, cmd.symbol} < SC_W'(ALPHABET);
    push_cmd.pattern_end = cmd.pattern_end;
    push_cmd.pattern_id = cmd.pattern_id;
    push_cmd.pid_ok = {2'b00, cmd.pattern_id} < PC_W'(MAX_PATTERNS);
  end

endmodule

`default_nettype wire

@@ design/mpbm_fifo.sv @@
// two-entry queue of classified requests
`default_nettype none

module mpbm_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire mpbm_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output mpbm_pkg::cmd_t      head
);

  mpbm_pkg::cmd_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full = (fill == 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head = slots[rd_ptr];

  // payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/mpbm_engine.sv @@
// trie store, link builder and scan sequencer
`default_nettype none

module mpbm_engine #(
  parameter int MAX_NODES = mpbm_pkg::MAX_NODES_DEF,
  parameter int ALPHABET = mpbm_pkg::ALPHABET_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_valid,
  input  wire mpbm_pkg::cmd_t head,
  output logic                pop,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output mpbm_pkg::out_t      rsp
);

  localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int GW = NW + AW;
  localparam int GDEPTH = MAX_NODES << AW;
  localparam int IW = mpbm_pkg::ID_W;
  localparam int CW = mpbm_pkg::CNT_W;
  localparam logic [AW-1:0] SYM_LAST = AW'(ALPHABET - 1);
  localparam logic [NW:0] NODE_LIMIT = (NW + 1)'(MAX_NODES);
  localparam logic [CW-1:0] CAP_LAST = CW'(mpbm_pkg::RESULT_CAP - 1);

  typedef struct packed {
    logic          vld;
    logic [NW-1:0] link;
  } chain_t;

  typedef struct packed {
    logic          vld;
    logic [IW-1:0] id;
  } end_t;

  typedef enum logic [18:0] {
    S_IDLE   = 19'h00001,
    S_LG     = 19'h00002,
    S_LP     = 19'h00004,
    S_ADD    = 19'h00008,
    S_SAFT   = 19'h00010,
    S_SREP   = 19'h00020,
    S_SCH    = 19'h00040,
    S_SCH2   = 19'h00080,
    S_BDEQ   = 19'h00100,
    S_BDEQ2  = 19'h00200,
    S_BCHILD = 19'h00400,
    S_PNEXT  = 19'h00800,
    S_PX     = 19'h01000,
    S_PP     = 19'h02000,
    S_FOLLOW = 19'h04000,
    S_PLOOP  = 19'h08000,
    S_PW     = 19'h10000,
    S_EMIT   = 19'h20000,
    S_SPARE  = 19'h40000
  } state_t;

  // memories
  logic [NW-1:0] goto_mem [GDEPTH];
  logic [NW-1:0] pnode_mem [MAX_NODES];
  logic [AW-1:0] psym_mem [MAX_NODES];
  logic [NW-1:0] fail_mem [MAX_NODES];
  chain_t        chain_mem [MAX_NODES];
  end_t          end_mem [MAX_NODES];
  logic [NW-1:0] bfs_mem [MAX_NODES];

  logic [NW-1:0] g_q, pn_q, f_q, q_q;
  logic [AW-1:0] ps_q;
  chain_t        c_q;
  end_t          e_q;

  // memory controls
  logic          g_re, g_we, p_re, p_we, f_re, f_we, nd_re, c_we, e_we, b_re, b_we;
  logic [GW-1:0] g_ra, g_wa;
  logic [NW-1:0] g_wd, p_ra, p_wa, pn_wd, f_ra, f_wa, f_wd, nd_ra, c_wa, e_wa;
  logic [NW-1:0] b_ra, b_wa, b_wd;
  logic [AW-1:0] ps_wd;
  chain_t        c_wd;
  end_t          e_wd;

  // registers
  state_t               state, state_next, ret, ret_next, eret, eret_next;
  logic [NW-1:0]        lk_node, lk_node_next, ins, ins_next, scan, scan_next;
  logic [AW-1:0]        lk_sym, lk_sym_next;
  logic [NW:0]          count, count_next, qhead, qhead_next, tail, tail_next;
  logic [NW:0]          idx, idx_next;
  logic [NW-1:0]        x, x_next, chl, chl_next;
  logic [CW-1:0]        n, n_next;
  logic                 vroot, vroot_next;
  logic [31:0]          tpos, tpos_next, pos, pos_next;
  mpbm_pkg::cmd_t       cur, cur_next;
  mpbm_pkg::out_t       res, res_next;

  logic   hit, o_free, load, mark;
  logic [NW-1:0] v, nxt;
  end_t   e_eff;
  chain_t c_eff;

  // goto entry counts only if its node still has that parent and symbol
  assign hit = (g_q != '0) && ({1'b0, g_q} < count) && (pn_q == lk_node) &&
               (ps_q == lk_sym);
  assign o_free = !rsp_valid || !rsp_stall;
  assign load = (state == S_EMIT) && o_free;
  assign e_eff = vroot ? '0 : e_q;
  assign c_eff = vroot ? '0 : c_q;
  assign mark = cur.pattern_end && cur.pid_ok;

  // memory ports
  always_ff @(posedge clk) begin
    if (g_we) begin
      goto_mem[g_wa] <= g_wd;
    end
    if (g_re) begin
      g_q <= goto_mem[g_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      pnode_mem[p_wa] <= pn_wd;
      psym_mem[p_wa] <= ps_wd;
    end
    if (p_re) begin
      pn_q <= pnode_mem[p_ra];
      ps_q <= psym_mem[p_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      fail_mem[f_wa] <= f_wd;
    end
    if (f_re) begin
      f_q <= fail_mem[f_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      chain_mem[c_wa] <= c_wd;
    end
    if (nd_re) begin
      c_q <= chain_mem[nd_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      end_mem[e_wa] <= e_wd;
    end
    if (nd_re) begin
      e_q <= end_mem[nd_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      bfs_mem[b_wa] <= b_wd;
    end
    if (b_re) begin
      q_q <= bfs_mem[b_ra];
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    ret_next = ret;
    eret_next = eret;
    lk_node_next = lk_node;
    lk_sym_next = lk_sym;
    ins_next = ins;
    scan_next = scan;
    count_next = count;
    qhead_next = qhead;
    tail_next = tail;
    idx_next = idx;
    x_next = x;
    chl_next = chl;
    n_next = n;
    vroot_next = vroot;
    tpos_next = tpos;
    pos_next = pos;
    cur_next = cur;
    res_next = res;
    pop = 1'b0;
    v = '0;
    nxt = '0;
    g_re = 1'b0; g_we = 1'b0; g_ra = {lk_node, lk_sym}; g_wa = {lk_node, lk_sym};
    g_wd = '0;
    p_re = 1'b0; p_we = 1'b0; p_ra = g_q; p_wa = '0; pn_wd = lk_node; ps_wd = lk_sym;
    f_re = 1'b0; f_we = 1'b0; f_ra = lk_node; f_wa = x; f_wd = '0;
    nd_re = 1'b0; nd_ra = g_q;
    c_we = 1'b0; c_wa = x; c_wd = '0;
    e_we = 1'b0; e_wa = '0; e_wd = '0;
    b_re = 1'b0; b_we = 1'b0; b_ra = qhead[NW-1:0]; b_wa = tail[NW-1:0]; b_wd = g_q;
    unique case (state)
      S_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          cur_next = head;
          res_next = '{status: mpbm_pkg::ST_DONE, position: '0, match_id: '0,
                       last: 1'b1};
          unique case (head.op)
            mpbm_pkg::OP_CLEAR: begin
              count_next = (NW + 1)'(1);
              ins_next = '0;
              scan_next = '0;
              tpos_next = '0;
              eret_next = S_IDLE;
              state_next = S_EMIT;
            end
            mpbm_pkg::OP_ADD: begin
              eret_next = S_IDLE;
              if (!head.sym_ok) begin
                state_next = S_EMIT;
              end else begin
                lk_node_next = ins;
                lk_sym_next = head.symbol[AW-1:0];
                ret_next = S_ADD;
                state_next = S_LG;
              end
            end
            mpbm_pkg::OP_BUILD: begin
              b_we = 1'b1;
              b_wa = '0;
              b_wd = '0;
              qhead_next = '0;
              tail_next = (NW + 1)'(1);
              state_next = S_BDEQ;
            end
            mpbm_pkg::OP_SCAN: begin
              pos_next = tpos;
              if (tpos != '1) begin
                tpos_next = tpos + 32'd1;
              end
              if (!head.sym_ok) begin
                scan_next = '0;
                vroot_next = 1'b1;
                state_next = S_SREP;
              end else begin
                lk_node_next = scan;
                lk_sym_next = head.symbol[AW-1:0];
                ret_next = S_SAFT;
                state_next = S_LG;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      // child lookup: goto entry, then its parent record
      S_LG: begin
        g_re = 1'b1;
        state_next = S_LP;
      end
      S_LP: begin
        p_re = 1'b1;
        p_ra = g_q;
        state_next = ret;
      end
      // insert one pattern byte
      S_ADD: begin
        res_next = '{status: mpbm_pkg::ST_DONE, position: '0, match_id: '0, last: 1'b1};
        eret_next = S_IDLE;
        state_next = S_EMIT;
        if (hit) begin
          nxt = g_q;
          e_we = mark;
        end else if (count >= NODE_LIMIT) begin
          ins_next = '0;
          res_next.status = mpbm_pkg::ST_FULL;
        end else begin
          nxt = count[NW-1:0];
          count_next = count + (NW + 1)'(1);
          g_we = 1'b1;
          g_wd = nxt;
          p_we = 1'b1;
          p_wa = nxt;
          f_we = 1'b1;
          f_wa = nxt;
          c_we = 1'b1;
          c_wa = nxt;
          e_we = 1'b1;
        end
        e_wa = nxt;
        e_wd = mark ? end_t'{vld: 1'b1, id: cur.pattern_id} : '0;
        if (hit || count < NODE_LIMIT) begin
          ins_next = cur.pattern_end ? '0 : nxt;
        end
      end
      // scan step: take the child or fall back along the failure link
      S_SAFT: begin
        if (hit) begin
          v = g_q;
          nd_re = 1'b1;
          nd_ra = v;
          scan_next = v;
          vroot_next = 1'b0;
          state_next = S_SREP;
        end else if (lk_node != '0) begin
          f_re = 1'b1;
          f_ra = lk_node;
          state_next = S_FOLLOW;
        end else begin
          v = '0;
          nd_re = 1'b1;
          nd_ra = v;
          scan_next = v;
          vroot_next = 1'b1;
          state_next = S_SREP;
        end
      end
      // report the reached node's own pattern, else walk its chain or report done
      S_SREP: begin
        res_next = '{status: mpbm_pkg::ST_MATCH, position: pos, match_id: e_eff.id,
                     last: !c_eff.vld};
        chl_next = c_eff.link;
        if (e_eff.vld) begin
          n_next = CW'(1);
          eret_next = c_eff.vld ? S_SCH : S_IDLE;
          state_next = S_EMIT;
        end else if (c_eff.vld) begin
          n_next = '0;
          state_next = S_SCH;
        end else begin
          res_next = '{status: mpbm_pkg::ST_DONE, position: pos, match_id: '0,
                       last: 1'b1};
          eret_next = S_IDLE;
          state_next = S_EMIT;
        end
      end
      // walk the match chain
      S_SCH: begin
        nd_re = 1'b1;
        nd_ra = chl;
        state_next = S_SCH2;
      end
      S_SCH2: begin
        res_next = '{status: mpbm_pkg::ST_MATCH, position: pos, match_id: e_q.id,
                     last: !(c_q.vld && n != CAP_LAST)};
        n_next = n + CW'(1);
        chl_next = c_q.link;
        eret_next = (c_q.vld && n != CAP_LAST) ? S_SCH : S_IDLE;
        state_next = S_EMIT;
      end
      // breadth-first order: dequeue a node
      S_BDEQ: begin
        if (qhead == tail) begin
          idx_next = (NW + 1)'(1);
          state_next = S_PNEXT;
        end else begin
          b_re = 1'b1;
          b_ra = qhead[NW-1:0];
          qhead_next = qhead + (NW + 1)'(1);
          state_next = S_BDEQ2;
        end
      end
      S_BDEQ2: begin
        lk_node_next = q_q;
        lk_sym_next = '0;
        ret_next = S_BCHILD;
        state_next = S_LG;
      end
      // enqueue children in symbol order
      S_BCHILD: begin
        if (hit) begin
          b_we = 1'b1;
          b_wa = tail[NW-1:0];
          b_wd = g_q;
          tail_next = tail + (NW + 1)'(1);
        end
        if (lk_sym == SYM_LAST) begin
          state_next = S_BDEQ;
        end else begin
          lk_sym_next = lk_sym + AW'(1);
          state_next = S_LG;
        end
      end
      // link pass over the queue
      S_PNEXT: begin
        if (idx == tail) begin
          res_next = '{status: mpbm_pkg::ST_DONE, position: '0, match_id: '0,
                       last: 1'b1};
          eret_next = S_IDLE;
          state_next = S_EMIT;
        end else begin
          b_re = 1'b1;
          b_ra = idx[NW-1:0];
          state_next = S_PX;
        end
      end
      S_PX: begin
        x_next = q_q;
        p_re = 1'b1;
        p_ra = q_q;
        state_next = S_PP;
      end
      S_PP: begin
        lk_sym_next = ps_q;
        if (pn_q == '0) begin
          f_we = 1'b1;
          c_we = 1'b1;
          idx_next = idx + (NW + 1)'(1);
          state_next = S_PNEXT;
        end else begin
          f_re = 1'b1;
          f_ra = pn_q;
          ret_next = S_PLOOP;
          state_next = S_FOLLOW;
        end
      end
      S_FOLLOW: begin
        lk_node_next = f_q;
        state_next = S_LG;
      end
      S_PLOOP: begin
        if (hit && g_q != x) begin
          nd_re = 1'b1;
          nd_ra = g_q;
          state_next = S_PW;
        end else if (hit || lk_node == '0) begin
          f_we = 1'b1;
          c_we = 1'b1;
          idx_next = idx + (NW + 1)'(1);
          state_next = S_PNEXT;
        end else begin
          f_re = 1'b1;
          f_ra = lk_node;
          state_next = S_FOLLOW;
        end
      end
      S_PW: begin
        f_we = 1'b1;
        f_wd = g_q;
        c_we = 1'b1;
        c_wd = e_q.vld ? chain_t'{vld: 1'b1, link: g_q} : c_q;
        idx_next = idx + (NW + 1)'(1);
        state_next = S_PNEXT;
      end
      // hand a result to the output register
      S_EMIT: begin
        if (o_free) begin
          state_next = eret;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= (NW + 1)'(1);
      ins <= '0;
      scan <= '0;
      tpos <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ins <= ins_next;
      scan <= scan_next;
      tpos <= tpos_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    ret <= ret_next;
    eret <= eret_next;
    lk_node <= lk_node_next;
    lk_sym <= lk_sym_next;
    qhead <= qhead_next;
    tail <= tail_next;
    idx <= idx_next;
    x <= x_next;
    chl <= chl_next;
    n <= n_next;
    vroot <= vroot_next;
    pos <= pos_next;
    cur <= cur_next;
    res <= res_next;
    if (load) begin
      rsp <= res;
    end
  end

endmodule

`default_nettype wire

@@ design/multi_pattern_byte_matcher.sv @@
// top level of the multi-pattern byte matcher
// scan: child lookup, failure-link steps on a miss, then the node's own match and its chain
// build: a breadth-first ordering pass over each node and symbol, then per-node link search
// throughput: one request at a time through the shared trie memories; requests queue two deep
// reset: synchronous, empties the trie, text position zero; no memory clearing pass is needed
`default_nettype none

module multi_pattern_byte_matcher #(
  parameter int MAX_NODES = mpbm_pkg::MAX_NODES_DEF,
  parameter int MAX_PATTERNS = mpbm_pkg::MAX_PATTERNS_DEF,
  parameter int ALPHABET = mpbm_pkg::ALPHABET_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_stall,
  input  wire mpbm_pkg::in_t cmd,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output mpbm_pkg::out_t     rsp
);

  logic           full, push, pop, head_valid;
  mpbm_pkg::cmd_t push_cmd, head;

  // request intake
  mpbm_front #(
    .MAX_PATTERNS(MAX_PATTERNS),
    .ALPHABET(ALPHABET)
  ) u_front (
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .full(full),
    .push(push),
    .push_cmd(push_cmd)
  );

  // decoupling queue
  mpbm_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_cmd(push_cmd),
    .full(full),
    .pop(pop),
    .head_valid(head_valid),
    .head(head)
  );

  // trie engine
  mpbm_engine #(
    .MAX_NODES(MAX_NODES),
    .ALPHABET(ALPHABET)
  ) u_engine (
    .clk(clk),
    .rst(rst),
    .head_valid(head_valid),
    .head(head),
    .pop(pop),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

endmodule

`default_nettype wire

@@ tb/tb_multi_pattern_byte_matcher.sv @@
// self-checking testbench of the multi-pattern byte matcher with a built-in trie predictor
`timescale 1ns / 1ps

module tb_multi_pattern_byte_matcher;

  localparam int NODES = mpbm_pkg::MAX_NODES_DEF;
  localparam int SYMS = mpbm_pkg::ALPHABET_DEF;
  localparam int TAIL_ITEMS = 60;
  localparam int ITEMS = 430;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  mpbm_pkg::in_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  mpbm_pkg::out_t rsp;

  multi_pattern_byte_matcher i_dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  // trie copy used for prediction
  logic [7:0] trie_next[NODES*SYMS];
  logic [7:0] fail_of[NODES];
  logic [7:0] chain_of[NODES];
  bit chain_ok[NODES];
  logic [mpbm_pkg::ID_W-1:0] end_id[NODES];
  bit end_ok[NODES];
  logic [7:0] parent_of[NODES];
  logic [7:0] psym_of[NODES];
  int node_total;
  int ins_node;
  int scan_at;
  logic [mpbm_pkg::POS_W-1:0] text_pos;

  mpbm_pkg::in_t request_q[$];
  mpbm_pkg::out_t expected_q[$];
  int total_requests;
  int sent_cnt = 0;
  int hold_at;
  int mismatches = 0;
  int send_gap = 0;
  int stall_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  function automatic mpbm_pkg::out_t mk_result(mpbm_pkg::status_t st,
                                               logic [mpbm_pkg::POS_W-1:0] pos,
                                               logic [mpbm_pkg::ID_W-1:0] id, logic lst);
    mpbm_pkg::out_t r;
    r.status = st;
    r.position = pos;
    r.match_id = id;
    r.last = lst;
    return r;
  endfunction

  // append one expected result
  function automatic void expect_result(mpbm_pkg::out_t r);
    expected_q.insert(expected_q.size(), r);
  endfunction

  function automatic void trie_clear();
    for (int i = 0; i < NODES*SYMS; i++) trie_next[i] = '0;
    for (int i = 0; i < NODES; i++) begin
      fail_of[i] = '0;
      chain_of[i] = '0;
      chain_ok[i] = 1'b0;
      end_id[i] = '0;
      end_ok[i] = 1'b0;
      parent_of[i] = '0;
      psym_of[i] = '0;
    end
    node_total = 1;
    ins_node = 0;
    scan_at = 0;
    text_pos = '0;
  endfunction

  // failure and chain links in breadth-first order
  function automatic void trie_build();
    int order[NODES];
    int head;
    int tail;
    int u;
    int x;
    int p;
    int c;
    int r;
    int t;
    head = 0;
    tail = 1;
    order[0] = 0;
    fail_of[0] = '0;
    chain_ok[0] = 1'b0;
    while (head < tail) begin
      u = order[head];
      head++;
      for (int s = 0; s < SYMS; s++) begin
        if (trie_next[u*SYMS+s] != 0 && tail < NODES) begin
          order[tail] = int'(trie_next[u*SYMS+s]);
          tail++;
        end
      end
    end
    for (int i = 1; i < tail; i++) begin
      x = order[i];
      p = int'(parent_of[x]);
      c = int'(psym_of[x]);
      fail_of[x] = '0;
      chain_ok[x] = 1'b0;
      chain_of[x] = '0;
      if (p != 0) begin
        r = int'(fail_of[p]);
        for (int g = 0; g < NODES; g++) begin
          if (trie_next[r*SYMS+c] != 0 || r == 0) break;
          r = int'(fail_of[r]);
        end
        t = int'(trie_next[r*SYMS+c]);
        if (t != 0 && t != x) begin
          fail_of[x] = 8'(t);
          if (end_ok[t]) begin
            chain_of[x] = 8'(t);
            chain_ok[x] = 1'b1;
          end else begin
            chain_of[x] = chain_of[t];
            chain_ok[x] = chain_ok[t];
          end
        end
      end
    end
  endfunction

  // expected results of one accepted request
  function automatic void trie_predict(mpbm_pkg::in_t req);
    int v;
    int t;
    int n;
    int c;
    bit ok;
    logic [mpbm_pkg::POS_W-1:0] pos;
    case (req.op)
      mpbm_pkg::OP_CLEAR: begin
        trie_clear();
        expect_result(mk_result(mpbm_pkg::ST_DONE, '0, '0, 1'b1));
      end
      mpbm_pkg::OP_ADD: begin
        v = ins_node;
        t = int'(trie_next[v*SYMS+req.symbol]);
        if (t == 0 && node_total >= NODES) begin
          ins_node = 0;
          expect_result(mk_result(mpbm_pkg::ST_FULL, '0, '0, 1'b1));
        end else begin
          if (t == 0) begin
            t = node_total;
            node_total++;
            parent_of[t] = 8'(v);
            psym_of[t] = req.symbol;
            fail_of[t] = '0;
            chain_of[t] = '0;
            chain_ok[t] = 1'b0;
            end_ok[t] = 1'b0;
            end_id[t] = '0;
            trie_next[v*SYMS+req.symbol] = 8'(t);
          end
          ins_node = t;
          if (req.pattern_end) begin
            end_id[t] = req.pattern_id;
            end_ok[t] = 1'b1;
            ins_node = 0;
          end
          expect_result(mk_result(mpbm_pkg::ST_DONE, '0, '0, 1'b1));
        end
      end
      mpbm_pkg::OP_BUILD: begin
        trie_build();
        expect_result(mk_result(mpbm_pkg::ST_DONE, '0, '0, 1'b1));
      end
      default: begin
        pos = text_pos;
        if (text_pos != '1) text_pos++;
        v = scan_at;
        for (int g = 0; g <= NODES; g++) begin
          t = int'(trie_next[v*SYMS+req.symbol]);
          if (t != 0) begin
            v = t;
            break;
          end
          if (v == 0) break;
          v = int'(fail_of[v]);
        end
        scan_at = v;
        n = 0;
        if (end_ok[v]) begin
          expect_result(mk_result(mpbm_pkg::ST_MATCH, pos, end_id[v], 1'b0));
          n++;
        end
        c = int'(chain_of[v]);
        ok = chain_ok[v];
        while (ok && n < mpbm_pkg::RESULT_CAP) begin
          expect_result(mk_result(mpbm_pkg::ST_MATCH, pos, end_id[c], 1'b0));
          n++;
          ok = chain_ok[c];
          c = int'(chain_of[c]);
        end
        if (n == 0) begin
          expect_result(mk_result(mpbm_pkg::ST_DONE, pos, '0, 1'b1));
        end else begin
          expected_q[expected_q.size()-1].last = 1'b1;
        end
      end
    endcase
  endfunction

  // stimulus helpers
  task automatic push_req(mpbm_pkg::op_t op, int sym, bit pend, int pid);
    mpbm_pkg::in_t r;
    r.op = op;
    r.symbol = 8'(sym);
    r.pattern_end = pend;
    r.pattern_id = 5'(pid);
    request_q.insert(request_q.size(), r);
  endtask

  task automatic push_pattern(string txt, int pid);
    for (int i = 0; i < txt.len(); i++)
      push_req(mpbm_pkg::OP_ADD, int'(txt[i]), i == txt.len() - 1, pid);
  endtask

  task automatic push_text(string txt);
    for (int i = 0; i < txt.len(); i++)
      push_req(mpbm_pkg::OP_SCAN, int'(txt[i]), 1'b0, int'($urandom_range(0, 31)));
  endtask

  function automatic int pick_symbol();
    if ($urandom_range(0, 99) < 85) return int'($urandom_range(8'h61, 8'h63));
    return int'($urandom_range(0, 255));
  endfunction

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || !cmd_stall) begin
      if (cmd_valid) begin
        trie_predict(cmd);
        sent_cnt++;
      end
      if (send_gap > 0) begin
        send_gap--;
        cmd_valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        cmd <= request_q.pop_front();
        cmd_valid <= 1'b1;
        if (sent_cnt < total_requests - TAIL_ITEMS && $urandom_range(0, 9) == 0)
          send_gap = int'($urandom_range(1, 13));
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, once
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && sent_cnt >= hold_at) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor and stall bursts
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d pos %0d id %0d last %0b",
                   rsp.status, rsp.position, rsp.match_id, rsp.last);
      end else begin
        mpbm_pkg::out_t exp_r;
        exp_r = expected_q.pop_front();
        if (rsp.status !== exp_r.status || rsp.position !== exp_r.position ||
            rsp.match_id !== exp_r.match_id || rsp.last !== exp_r.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                     exp_r.status, exp_r.position, exp_r.match_id, exp_r.last,
                     rsp.status, rsp.position, rsp.match_id, rsp.last);
        end
      end
    end
    if (stall_gap > 0) begin
      stall_gap--;
    end else if (sent_cnt < total_requests - TAIL_ITEMS && $urandom_range(0, 11) == 0) begin
      stall_gap = int'($urandom_range(1, 13));
    end
    rsp_stall <= (hold_left > 0) || (stall_gap > 0);
  end

  // stimulus, reset and end of run
  initial begin
    int npat;
    int len;
    int nscan;
    trie_clear();
    // directed: classic pattern set, scan before build, extremes
    push_req(mpbm_pkg::OP_CLEAR, 0, 1'b0, 0);
    push_text("x");
    push_pattern("he", 1);
    push_pattern("she", 2);
    push_pattern("his", 3);
    push_pattern("hers", 4);
    push_text("she");
    push_req(mpbm_pkg::OP_BUILD, 0, 1'b0, 0);
    push_text("ushers");
    push_req(mpbm_pkg::OP_ADD, 0, 1'b0, 31);
    push_req(mpbm_pkg::OP_ADD, 255, 1'b1, 31);
    push_req(mpbm_pkg::OP_ADD, 255, 1'b1, 0);
    push_pattern("he", 7);
    push_req(mpbm_pkg::OP_BUILD, 0, 1'b0, 0);
    push_req(mpbm_pkg::OP_SCAN, 0, 1'b0, 0);
    push_req(mpbm_pkg::OP_SCAN, 255, 1'b1, 31);
    push_text("he");
    // clear, then fill the node store past full
    push_req(mpbm_pkg::OP_CLEAR, 0, 1'b0, 0);
    for (int i = 0; i < NODES + 1; i++) push_req(mpbm_pkg::OP_ADD, i % 256, 1'b0, 0);
    push_req(mpbm_pkg::OP_ADD, 8'h41, 1'b1, 5);
    push_text("A");
    // random dictionaries and texts
    while (request_q.size() < ITEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        push_req(mpbm_pkg::OP_CLEAR, 0, 1'b0, 0);
      end
      npat = int'($urandom_range(2, 6));
      for (int p = 0; p < npat; p++) begin
        len = int'($urandom_range(1, 4));
        for (int i = 0; i < len; i++)
          push_req(mpbm_pkg::OP_ADD, pick_symbol(), i == len - 1,
                   int'($urandom_range(0, 31)));
      end
      if ($urandom_range(0, 2) == 0) begin
        push_req(mpbm_pkg::OP_ADD, pick_symbol(), 1'b0, int'($urandom_range(0, 31)));
      end
      if ($urandom_range(0, 7) != 0) begin
        push_req(mpbm_pkg::OP_BUILD, 0, 1'b0, 0);
      end
      nscan = int'($urandom_range(15, 35));
      for (int i = 0; i < nscan; i++)
        push_req(mpbm_pkg::OP_SCAN, pick_symbol(), bit'($urandom_range(0, 1)),
                 int'($urandom_range(0, 31)));
    end
    total_requests = request_q.size();
    hold_at = total_requests - 200;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait (request_q.size() == 0 && !cmd_valid && expected_q.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
